@@ rtl/gspc_pkg.sv @@
// ----------------------------------------------------------------------------
// gspc_pkg: shared types and constants for the gas sensor ppm converter
// Fixed-point widths, status and register codes, sequencer states, and the
// constant tables that are built at elaboration (square-root chain, log2(10)).
// ----------------------------------------------------------------------------
package gspc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LOG_W     = FRAC_BITS + 7;   // sign + 6 integer bits + fraction
	localparam int D_W       = FRAC_BITS + 10;  // log-domain differences
	localparam int NUM_W     = D_W + 12;        // dividend magnitude
	localparam int Y_W       = FRAC_BITS + 24;  // exponent argument
	localparam int CNT_W     = $clog2(NUM_W + 1);
	localparam int ROOT_IW   = $clog2(FRAC_BITS);
	localparam int RO_W      = 40;
	localparam int PPM_W     = 24;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_PRIME_FAIL = 3'd1,
		STAT_MEAS_FAIL  = 3'd2,
		STAT_NOT_PRIMED = 3'd3,
		STAT_RANGE      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_SLOPE     = 2'd0,
		CFG_INTERCEPT = 2'd1,
		CFG_AMBIENT   = 2'd2,
		CFG_SUPPLY    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BTERM,
		ST_PRIME_CHK,
		ST_LOG_LOAD,
		ST_LOG_NORM,
		ST_LOG_SQ,
		ST_LOG_DONE,
		ST_RATIO,
		ST_EXP_MUL,
		ST_EXP_FIN,
		ST_MEAS_CHK,
		ST_DIFF,
		ST_DIV,
		ST_DIV_FIN,
		ST_OUT
	} state_t;

	typedef logic [FRAC_BITS-1:0][30:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] rest;
		res   = '0;
		bit_v = 64'd1 << 62;
		rest  = v;
		for (int i = 0; i < 32; i++) begin
			if (rest >= res + bit_v) begin
				rest = rest - (res + bit_v);
				res  = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// c(i) = 2^(2^-(i+1)) in Q1.30, each a truncated square root of the last
	function automatic root_tab_t gen_roots();
		root_tab_t tab;
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int i = 0; i < FRAC_BITS; i++) begin
			c      = isqrt64(c << 30);
			tab[i] = c[30:0];
		end
		return tab;
	endfunction

	function automatic logic signed [LOG_W-1:0] log2_const(input logic [63:0] x);
		logic [5:0]           e;
		logic [63:0]          mant;
		logic [FRAC_BITS-1:0] b;
		e = '0;
		for (int i = 0; i < 63; i++) begin
			if ((x >> (i + 1)) != 64'd0) e = 6'(i + 1);
		end
		mant = (e <= 6'd30) ? (x << (6'd30 - e)) : (x >> (e - 6'd30));
		b = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			mant = (mant * mant) >> 30;
			b    = b << 1;
			if (mant >= (64'd1 << 31)) begin
				mant = mant >> 1;
				b[0] = 1'b1;
			end
		end
		return {1'b0, e, b};
	endfunction

	localparam root_tab_t             ROOT_TAB = gen_roots();
	localparam logic signed [LOG_W-1:0] LG10   = log2_const(64'd10);

endpackage

@@ rtl/gas_sensor_ppm_converter.sv @@
// Priming adds its own log2 and exp2 passes before the measurement; items stopped by a
//   check before any log2 go straight to the result register.
// Throughput: one item at a time, the next can be accepted in the cycle after the result
//   register loads; the shared 33x33 multiplier and the one-bit divider step set the length.
// Reset: asynchronous, active low; clears reference and primed flag, loads defaults.
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter: MQ-style power-law ppm conversion
// Priming derives the clean-air reference from a priming code; each item then
// turns its sample code into ppm via log2, a divide by the slope and exp2,
// all on one multiplier and one divider step under a small sequencer.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] recalibrate, [16:1] prime_code, [17] prime_fail, [33:18] sample_code,
	// [34] sample_fail, [39:35] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [23:0] ppm_q4, [26:24] status, [31:27] zero
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import gspc_pkg::*;

	localparam logic signed [Y_W-1:0] SHL_MAX  = Y_W'(32);
	localparam logic signed [Y_W-1:0] SHR_MAX  = Y_W'(40);
	localparam logic signed [D_W-1:0] RO_SCALE = D_W'(20) <<< FRAC_BITS;

	state_t state_q, state_d;

	logic signed [15:0] slope_q, icpt_q;
	logic [15:0]        amb_q;
	logic [16:0]        supply_q;

	logic               recal_q, pfail_q, sfail_q;
	logic signed [15:0] pcode_q, scode_q;

	logic               primed_q;
	logic [RO_W-1:0]    ro_q;
	logic               meas_q;
	logic [1:0]         lidx_q;

	logic signed [D_W-1:0]   bterm_q;
	logic signed [LOG_W-1:0] l_q [3];
	logic [39:0]             x_q;
	logic [5:0]              e_q;
	logic [30:0]             mant_q;
	logic [FRAC_BITS-1:0]    bits_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [Y_W-1:0]   y_q;
	logic [FRAC_BITS-1:0]    f_q;
	logic [30:0]             r_q;
	logic [NUM_W-1:0]        dv_q;
	logic [15:0]             rem_q;
	logic                    neg_q;

	logic [PPM_W-1:0] res_ppm_q, out_ppm_q;
	status_t          res_stat_q, out_stat_q;
	logic             out_valid_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	logic [39:0]             log_opnd;
	logic [31:0]             sq;
	logic signed [Y_W-1:0]   y_ratio, y_div, k_exp, s_exp, ns_exp;
	logic [63:0]             maxv, wide, exp_v;
	logic signed [D_W-1:0]   diff;
	logic signed [NUM_W:0]   num;
	logic [16:0]             trial, dsr;
	logic                    qbit;
	logic                    prime_ok, meas_ok, cnt_f_end, cnt_d_end;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_stat_q, out_ppm_q};

	assign cnt_f_end = (cnt_q == CNT_W'(FRAC_BITS - 1));
	assign cnt_d_end = (cnt_q == CNT_W'(NUM_W - 1));

	assign prime_ok = !pcode_q[15] && ({1'b0, pcode_q[15:0]} < supply_q);
	assign meas_ok  = !scode_q[15] && ({1'b0, scode_q[15:0]} < supply_q) && (slope_q != 16'sd0);

	always_comb begin
		log_opnd = '0;
		case (lidx_q)
			2'd0: log_opnd = meas_q ? 40'(supply_q) - 40'(scode_q[15:0])
			                        : 40'(supply_q) - 40'(pcode_q[15:0]);
			2'd1: log_opnd = meas_q ? 40'(scode_q[15:0]) : 40'(pcode_q[15:0]);
			2'd2: log_opnd = meas_q ? ro_q : ((amb_q == 16'd0) ? 40'd1 : 40'(amb_q));
			default: log_opnd = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_BTERM: begin
				mul_a = 33'(icpt_q);
				mul_b = 33'(LG10);
			end
			ST_RATIO: begin
				mul_a = 33'(slope_q);
				mul_b = 33'(l_q[2]);
			end
			ST_LOG_SQ: begin
				mul_a = {2'b00, mant_q};
				mul_b = {2'b00, mant_q};
			end
			ST_EXP_MUL: begin
				mul_a = {2'b00, r_q};
				mul_b = {2'b00, ROOT_TAB[cnt_q[ROOT_IW-1:0]]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;
	assign sq   = prod[61:30];

	// log ratio of priming: lrs - (floor(m*log2 amb) + b*log2 10)
	assign y_ratio = Y_W'(l_q[0]) - Y_W'(l_q[1])
		- (Y_W'(prod[Y_W+11:12]) + Y_W'(bterm_q));

	assign diff = D_W'(l_q[0]) - D_W'(l_q[1]) - (D_W'(l_q[2]) - RO_SCALE) - bterm_q;
	assign num  = (NUM_W+1)'(diff) <<< 12;

	assign dsr   = {1'b0, slope_q[15] ? 16'(-slope_q) : slope_q[15:0]};
	assign trial = {rem_q, dv_q[NUM_W-1]};
	assign qbit  = (trial >= dsr);
	assign y_div = neg_q ? -Y_W'(dv_q) : Y_W'(dv_q);

	// scale 2^f by 2^(k+q-30), round half up, saturate
	always_comb begin
		k_exp  = y_q >>> FRAC_BITS;
		s_exp  = k_exp + (meas_q ? Y_W'(4) : Y_W'(20)) - Y_W'(30);
		ns_exp = -s_exp;
		maxv   = meas_q ? ((64'd1 << PPM_W) - 64'd1) : ((64'd1 << RO_W) - 64'd1);
		wide   = '0;
		exp_v  = '0;
		if (!s_exp[Y_W-1]) begin
			if (s_exp > SHL_MAX) begin
				exp_v = maxv;
			end else begin
				wide  = {33'd0, r_q} << s_exp[5:0];
				exp_v = (wide > maxv) ? maxv : wide;
			end
		end else begin
			if (ns_exp > SHR_MAX) begin
				exp_v = '0;
			end else begin
				wide  = ({33'd0, r_q} + (64'd1 << (ns_exp[5:0] - 6'd1))) >> ns_exp[5:0];
				exp_v = (wide > maxv) ? maxv : wide;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_axis_tvalid) state_d = ST_BTERM;
			ST_BTERM:     state_d = ST_PRIME_CHK;
			ST_PRIME_CHK: begin
				if (primed_q) state_d = ST_MEAS_CHK;
				else if (pfail_q || pcode_q == 16'sd0) state_d = ST_OUT;
				else if (prime_ok) state_d = ST_LOG_LOAD;
				else state_d = ST_MEAS_CHK;
			end
			ST_LOG_LOAD:  state_d = ST_LOG_NORM;
			ST_LOG_NORM: begin
				if (x_q[39]) state_d = ST_LOG_SQ;
				else if (x_q == 40'd0) state_d = ST_LOG_DONE;
			end
			ST_LOG_SQ:    if (cnt_f_end) state_d = ST_LOG_DONE;
			ST_LOG_DONE: begin
				if (lidx_q != 2'd2) state_d = ST_LOG_LOAD;
				else if (meas_q) state_d = ST_DIFF;
				else state_d = ST_RATIO;
			end
			ST_RATIO:     state_d = ST_EXP_MUL;
			ST_EXP_MUL:   if (cnt_f_end) state_d = ST_EXP_FIN;
			ST_EXP_FIN:   state_d = meas_q ? ST_OUT : ST_MEAS_CHK;
			ST_MEAS_CHK: begin
				if (sfail_q || scode_q == 16'sd0 || !primed_q || !meas_ok) state_d = ST_OUT;
				else state_d = ST_LOG_LOAD;
			end
			ST_DIFF:      state_d = ST_DIV;
			ST_DIV:       if (cnt_d_end) state_d = ST_DIV_FIN;
			ST_DIV_FIN:   state_d = ST_EXP_MUL;
			ST_OUT:       if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control, configuration and reference state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q     <= -16'sd1720;
			icpt_q      <= 16'sd3113;
			amb_q       <= 16'd400;
			supply_q    <= 17'd80000;
			primed_q    <= 1'b0;
			ro_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SLOPE:     slope_q  <= cfg_data[15:0];
					CFG_INTERCEPT: icpt_q   <= cfg_data[15:0];
					CFG_AMBIENT:   amb_q    <= cfg_data[15:0];
					CFG_SUPPLY:    supply_q <= cfg_data;
					default:       ;
				endcase
			end
			if (state_q == ST_BTERM && recal_q) begin
				primed_q <= 1'b0;
				ro_q     <= '0;
			end
			if (state_q == ST_EXP_FIN && !meas_q && exp_v != 64'd0) begin
				primed_q <= 1'b1;
				ro_q     <= exp_v[RO_W-1:0];
			end
			if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				recal_q <= s_axis_tdata[0];
				pcode_q <= s_axis_tdata[16:1];
				pfail_q <= s_axis_tdata[17];
				scode_q <= s_axis_tdata[33:18];
				sfail_q <= s_axis_tdata[34];
			end
			ST_BTERM: bterm_q <= prod[D_W+11:12];
			ST_PRIME_CHK: begin
				meas_q <= 1'b0;
				lidx_q <= 2'd0;
				res_ppm_q  <= '0;
				res_stat_q <= STAT_PRIME_FAIL;
			end
			ST_LOG_LOAD: begin
				x_q    <= log_opnd;
				e_q    <= 6'd39;
				bits_q <= '0;
				cnt_q  <= '0;
			end
			ST_LOG_NORM: begin
				if (x_q[39]) begin
					mant_q <= x_q[39:9];
				end else if (x_q == 40'd0) begin
					e_q <= 6'd0;
				end else if (x_q[39:32] == 8'd0) begin
					x_q <= x_q << 8;
					e_q <= e_q - 6'd8;
				end else begin
					x_q <= x_q << 1;
					e_q <= e_q - 6'd1;
				end
			end
			ST_LOG_SQ: begin
				mant_q <= sq[31] ? sq[31:1] : sq[30:0];
				bits_q <= {bits_q[FRAC_BITS-2:0], sq[31]};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_LOG_DONE: begin
				l_q[lidx_q] <= {1'b0, e_q, bits_q};
				lidx_q      <= lidx_q + 2'd1;
			end
			ST_RATIO: begin
				y_q   <= y_ratio;
				f_q   <= y_ratio[FRAC_BITS-1:0];
				r_q   <= 31'd1 << 30;
				cnt_q <= '0;
			end
			ST_EXP_MUL: begin
				if (f_q[FRAC_BITS-1]) r_q <= prod[60:30];
				f_q   <= f_q << 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_EXP_FIN: begin
				res_ppm_q  <= exp_v[PPM_W-1:0];
				res_stat_q <= STAT_OK;
			end
			ST_MEAS_CHK: begin
				meas_q    <= 1'b1;
				lidx_q    <= 2'd0;
				res_ppm_q <= '0;
				if (sfail_q || scode_q == 16'sd0) res_stat_q <= STAT_MEAS_FAIL;
				else if (!primed_q) res_stat_q <= STAT_NOT_PRIMED;
				else res_stat_q <= STAT_RANGE;
			end
			ST_DIFF: begin
				neg_q <= num[NUM_W] ^ slope_q[15];
				dv_q  <= num[NUM_W] ? NUM_W'(-num) : num[NUM_W-1:0];
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? 16'(trial - dsr) : trial[15:0];
				dv_q  <= {dv_q[NUM_W-2:0], qbit};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DIV_FIN: begin
				y_q   <= y_div;
				f_q   <= y_div[FRAC_BITS-1:0];
				r_q   <= 31'd1 << 30;
				cnt_q <= '0;
			end
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_ppm_q  <= res_ppm_q;
					out_stat_q <= res_stat_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/gspc_checker.sv @@
// ----------------------------------------------------------------------------
// gspc_checker: port-level checks for the gas sensor ppm converter
// Watches the stream ports for result hold, legal status, zeroed ppm on
// error and one-item-at-a-time acceptance.
// ----------------------------------------------------------------------------
module gspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import gspc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[26:24] <= STAT_RANGE)
		else $error("status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26:24] != STAT_OK |-> m_axis_tdata[23:0] == 24'd0)
		else $error("ppm nonzero on error status");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

endmodule

bind gas_sensor_ppm_converter gspc_checker u_gspc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
